// ===== sv/pmc_pkg.sv =====
// ----------------------------------------------------------------------------
// pmc_pkg
// Shared widths, per-degree factor tables and controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none
package pmc_pkg;

  localparam int MOM_W       = 32;
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int MAX_DEGREE  = 63;

  localparam int W2_W   = 17;
  localparam int PROD_W = W2_W + MOM_W;
  localparam int ACC_W  = PROD_W + ADDR_W + 1;
  localparam int SC_W   = 25;
  localparam int CP_W   = 9;
  localparam int DEN_W  = 25;
  localparam int NUM_W  = 64;
  localparam int QSH    = MOM_W - 1;

  // scale numerator 2 l^2 (l-1)^2
  function automatic logic [STORE_DEPTH*SC_W-1:0] sc_rom_f();
    logic [STORE_DEPTH*SC_W-1:0] r;
    int v;
    r = '0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      v = 2 * i * i * (i - 1) * (i - 1);
      r[i*SC_W +: SC_W] = v[SC_W-1:0];
    end
    return r;
  endfunction

  // coupling numerator 4 (2l+1)
  function automatic logic [STORE_DEPTH*CP_W-1:0] cp_rom_f();
    logic [STORE_DEPTH*CP_W-1:0] r;
    int v;
    r = '0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      v = 4 * (2 * i + 1);
      r[i*CP_W +: CP_W] = v[CP_W-1:0];
    end
    return r;
  endfunction

  // common denominator 2 l (l-1) (l+1) (l+2)
  function automatic logic [STORE_DEPTH*DEN_W-1:0] den_rom_f();
    logic [STORE_DEPTH*DEN_W-1:0] r;
    int v;
    r = '0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      v = 2 * i * (i - 1) * (i + 1) * (i + 2);
      r[i*DEN_W +: DEN_W] = v[DEN_W-1:0];
    end
    return r;
  endfunction

  localparam logic [STORE_DEPTH*SC_W-1:0]  SC_ROM  = sc_rom_f();
  localparam logic [STORE_DEPTH*CP_W-1:0]  CP_ROM  = cp_rom_f();
  localparam logic [STORE_DEPTH*DEN_W-1:0] DEN_ROM = den_rom_f();

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              mac;
    logic              term;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] deg;
    logic              acc_clr;
    logic              emit;
    logic              emit_zero;
    logic              eor;
    logic              ovf;
  } pmc_cmd_t;

  typedef struct packed {
    logic div_done;
  } pmc_sts_t;

endpackage
`default_nettype wire

// ===== sv/pmc_div.sv =====
// ----------------------------------------------------------------------------
// pmc_div
// Restoring divider, one quotient bit per cycle, round half away, saturate.
// ----------------------------------------------------------------------------
`default_nettype none
module pmc_div (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic signed [pmc_pkg::NUM_W-1:0]  num,
  input  wire logic [pmc_pkg::DEN_W-1:0]         den,
  output logic                                   done,
  output logic signed [pmc_pkg::MOM_W-1:0]       quo
);

  localparam int DSH_W = pmc_pkg::DEN_W + pmc_pkg::QSH;
  localparam int CNT_W = $clog2(pmc_pkg::MOM_W);

  logic                        run_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        neg_r;
  logic [pmc_pkg::NUM_W-1:0]   rem_r;
  logic [DSH_W-1:0]            dsh_r;
  logic [pmc_pkg::MOM_W-1:0]   q_r;
  logic [pmc_pkg::NUM_W-1:0]   mag;
  logic [pmc_pkg::NUM_W-1:0]   dext;
  logic                        ge;

  assign mag  = num[pmc_pkg::NUM_W-1] ? pmc_pkg::NUM_W'(-num) : pmc_pkg::NUM_W'(num);
  assign dext = pmc_pkg::NUM_W'(dsh_r);
  assign ge   = rem_r >= dext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == '0);
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(pmc_pkg::MOM_W - 1);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[pmc_pkg::NUM_W-1];
      rem_r <= mag + pmc_pkg::NUM_W'(den >> 1);
      dsh_r <= {den, {pmc_pkg::QSH{1'b0}}};
      q_r   <= '0;
    end else if (run_r) begin
      if (ge) rem_r <= rem_r - dext;
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[pmc_pkg::MOM_W-2:0], ge};
    end
  end

  always_comb begin
    priority if (q_r[pmc_pkg::MOM_W-1]) begin
      quo = neg_r ? {1'b1, {(pmc_pkg::MOM_W-1){1'b0}}} : {1'b0, {(pmc_pkg::MOM_W-1){1'b1}}};
    end else if (neg_r) begin
      quo = -$signed(q_r);
    end else begin
      quo = $signed(q_r);
    end
  end

  assign done = done_r;

endmodule
`default_nettype wire

// ===== sv/pmc_dp.sv =====
// ----------------------------------------------------------------------------
// pmc_dp
// Moment stores, weighted MAC pipeline, final combine, dividers, output regs.
// ----------------------------------------------------------------------------
`default_nettype none
module pmc_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire pmc_pkg::pmc_cmd_t                   cmd,
  output pmc_pkg::pmc_sts_t                        sts,
  input  wire logic signed [pmc_pkg::MOM_W-1:0]    in_beta11_moment,
  input  wire logic signed [pmc_pkg::MOM_W-1:0]    in_beta22_moment,
  input  wire logic signed [pmc_pkg::MOM_W-1:0]    in_delta33_moment,
  output logic                                     out_valid,
  output logic signed [pmc_pkg::MOM_W-1:0]         out_alpha_moment,
  output logic signed [pmc_pkg::MOM_W-1:0]         out_zeta_moment,
  output logic                                     out_end_of_run,
  output logic                                     out_overflowed
);

  localparam int AW = pmc_pkg::ADDR_W;

  logic signed [pmc_pkg::MOM_W-1:0] b11_mem [pmc_pkg::STORE_DEPTH];
  logic signed [pmc_pkg::MOM_W-1:0] b22_mem [pmc_pkg::STORE_DEPTH];
  logic signed [pmc_pkg::MOM_W-1:0] d33_mem [pmc_pkg::STORE_DEPTH];

  logic signed [pmc_pkg::MOM_W-1:0]  b11_r, b22_r, d33_r;
  logic                              mac_v_r, term_v_r, odd_r;
  logic signed [pmc_pkg::W2_W-1:0]   w2_r;
  logic [pmc_pkg::SC_W-1:0]          sc_r;
  logic [pmc_pkg::CP_W-1:0]          cp_r;
  logic [pmc_pkg::DEN_W-1:0]         den_r;
  logic signed [pmc_pkg::PROD_W-1:0] pz_r, pa_r;
  logic                              pv_r, pneg_r;
  logic signed [pmc_pkg::ACC_W-1:0]  accz_r, acca_r;
  logic signed [pmc_pkg::SC_W+pmc_pkg::MOM_W:0] scz_r, sca_r;
  logic signed [pmc_pkg::NUM_W-1:0]  cpz_r, cpa_r, numz_r, numa_r;
  logic                              tv1_r, tv2_r, tv3_r;
  logic                              out_valid_r, eor_r, ovf_r;
  logic signed [pmc_pkg::MOM_W-1:0]  alpha_r, zeta_r;

  logic [AW-1:0]                     lm1, gm1;
  logic [AW:0]                       lsum;
  logic [2*AW:0]                     base2;
  logic [AW+AW+2:0]                  tdec;
  logic signed [pmc_pkg::W2_W-1:0]   w2;
  logic signed [pmc_pkg::PROD_W-1:0] pz_w, pa_w;
  logic signed [pmc_pkg::SC_W+pmc_pkg::MOM_W:0] scz_w, sca_w;
  logic signed [pmc_pkg::CP_W+pmc_pkg::ACC_W:0] cpz_w, cpa_w;
  logic signed [pmc_pkg::MOM_W-1:0]  qz, qa;
  logic                              dz_done, da_done;

  // weight*2 = 2(l-1)^2 - 3(gap-1)(l+order)
  always_comb begin
    lm1   = cmd.deg - AW'(1);
    gm1   = cmd.deg - cmd.addr - AW'(1);
    lsum  = {1'b0, cmd.deg} + {1'b0, cmd.addr};
    base2 = (2*AW+1)'({lm1, 1'b0}) * (2*AW+1)'(lm1);
    tdec  = (AW+AW+3)'(gm1) * (AW+AW+3)'(lsum) * (AW+AW+3)'(3);
    w2    = $signed(pmc_pkg::W2_W'(base2)) - $signed(pmc_pkg::W2_W'(tdec));
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      b11_mem[cmd.wr_addr] <= in_beta11_moment;
      b22_mem[cmd.wr_addr] <= in_beta22_moment;
      d33_mem[cmd.wr_addr] <= in_delta33_moment;
    end
    if (cmd.mac || cmd.term) begin
      b11_r <= b11_mem[cmd.addr];
      b22_r <= b22_mem[cmd.addr];
      d33_r <= d33_mem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    w2_r  <= w2;
    odd_r <= cmd.deg[0] ^ cmd.addr[0];
    if (cmd.term) begin
      sc_r  <= pmc_pkg::SC_ROM[cmd.deg*pmc_pkg::SC_W +: pmc_pkg::SC_W];
      cp_r  <= pmc_pkg::CP_ROM[cmd.deg*pmc_pkg::CP_W +: pmc_pkg::CP_W];
      den_r <= pmc_pkg::DEN_ROM[cmd.deg*pmc_pkg::DEN_W +: pmc_pkg::DEN_W];
    end
  end

  // even gap: +d33 / +b11, odd gap: -b22 / -d33
  assign pz_w  = w2_r * (odd_r ? b22_r : d33_r);
  assign pa_w  = w2_r * (odd_r ? d33_r : b11_r);
  assign scz_w = $signed({1'b0, sc_r}) * d33_r;
  assign sca_w = $signed({1'b0, sc_r}) * b11_r;
  assign cpz_w = $signed({1'b0, cp_r}) * accz_r;
  assign cpa_w = $signed({1'b0, cp_r}) * acca_r;

  always_ff @(posedge clk) begin
    pz_r   <= pz_w;
    pa_r   <= pa_w;
    pneg_r <= odd_r;
    if (term_v_r) begin
      scz_r <= scz_w;
      sca_r <= sca_w;
    end
    if (tv1_r) begin
      cpz_r <= cpz_w[pmc_pkg::NUM_W-1:0];
      cpa_r <= cpa_w[pmc_pkg::NUM_W-1:0];
    end
    if (tv2_r) begin
      numz_r <= pmc_pkg::NUM_W'(scz_r) - cpz_r;
      numa_r <= pmc_pkg::NUM_W'(sca_r) - cpa_r;
    end
    if (cmd.acc_clr) begin
      accz_r <= '0;
      acca_r <= '0;
    end else if (pv_r) begin
      accz_r <= pneg_r ? accz_r - pmc_pkg::ACC_W'(pz_r) : accz_r + pmc_pkg::ACC_W'(pz_r);
      acca_r <= pneg_r ? acca_r - pmc_pkg::ACC_W'(pa_r) : acca_r + pmc_pkg::ACC_W'(pa_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_v_r     <= 1'b0;
      term_v_r    <= 1'b0;
      pv_r        <= 1'b0;
      tv1_r       <= 1'b0;
      tv2_r       <= 1'b0;
      tv3_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mac_v_r     <= cmd.mac;
      term_v_r    <= cmd.term;
      pv_r        <= mac_v_r;
      tv1_r       <= term_v_r;
      tv2_r       <= tv1_r;
      tv3_r       <= tv2_r;
      out_valid_r <= cmd.emit;
    end
  end

  pmc_div u_div_z (
    .clk   (clk),
    .rst_n (rst_n),
    .start (tv3_r),
    .num   (numz_r),
    .den   (den_r),
    .done  (dz_done),
    .quo   (qz)
  );

  pmc_div u_div_a (
    .clk   (clk),
    .rst_n (rst_n),
    .start (tv3_r),
    .num   (numa_r),
    .den   (den_r),
    .done  (da_done),
    .quo   (qa)
  );

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      alpha_r <= cmd.emit_zero ? '0 : qa;
      zeta_r  <= cmd.emit_zero ? '0 : qz;
      eor_r   <= cmd.eor;
      ovf_r   <= cmd.ovf;
    end
  end

  assign sts.div_done   = dz_done & da_done;
  assign out_valid        = out_valid_r;
  assign out_alpha_moment = alpha_r;
  assign out_zeta_moment  = zeta_r;
  assign out_end_of_run   = eor_r;
  assign out_overflowed   = ovf_r;

endmodule
`default_nettype wire

// ===== sv/pmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pmc_ctrl
// Load counter and per-degree sequencer for the completion datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module pmc_ctrl #(
  parameter int MAX_DEGREE = pmc_pkg::MAX_DEGREE
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                in_last,
  output logic                     busy,
  output pmc_pkg::pmc_cmd_t        cmd,
  input  wire pmc_pkg::pmc_sts_t   sts
);

  localparam int AW = pmc_pkg::ADDR_W;
  localparam int CW = pmc_pkg::CNT_W;
  localparam logic [CW-1:0] CAP = CW'(MAX_DEGREE + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_NEXT = 5'b00010,
    ST_MAC  = 5'b00100,
    ST_TERM = 5'b01000,
    ST_WAIT = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [AW-1:0] l_r, l_nxt;
  logic [AW-1:0] ord_r, ord_nxt;
  logic          eor;

  assign eor = ({1'b0, l_r} + CW'(1)) == cnt_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    l_nxt     = l_r;
    ord_nxt   = ord_r;
    cmd       = '0;
    cmd.wr_addr = cnt_r[AW-1:0];
    cmd.deg     = l_r;
    cmd.addr    = ord_r;
    cmd.eor     = eor;
    cmd.ovf     = ovf_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (cnt_r < CAP) begin
            cmd.wr_en = 1'b1;
            cnt_nxt   = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            l_nxt     = '0;
            state_nxt = ST_NEXT;
          end
        end
      end
      ST_NEXT: begin
        if (l_r < AW'(2)) begin
          cmd.emit      = 1'b1;
          cmd.emit_zero = 1'b1;
          if (eor) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            l_nxt = l_r + AW'(1);
          end
        end else begin
          cmd.acc_clr = 1'b1;
          ord_nxt     = '0;
          state_nxt   = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd.mac = 1'b1;
        ord_nxt = ord_r + AW'(1);
        if (ord_r == l_r - AW'(1)) state_nxt = ST_TERM;
      end
      ST_TERM: begin
        cmd.term  = 1'b1;
        cmd.addr  = l_r;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts.div_done) begin
          cmd.emit = 1'b1;
          if (eor) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            l_nxt     = l_r + AW'(1);
            state_nxt = ST_NEXT;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      l_r     <= '0;
      ord_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      l_r     <= l_nxt;
      ord_r   <= ord_nxt;
    end
  end

  assign busy = state_r != ST_IDLE;

endmodule
`default_nettype wire

// ===== sv/phase_moment_completion_core.sv =====
// ----------------------------------------------------------------------------
// phase_moment_completion_core
// Loads beta11/beta22/delta33 moments per degree, then emits alpha and zeta.
//
//   channel  | handshake      | beat contents
//   ---------+----------------+------------------------------------------
//   input    | start & !busy  | in_beta11/beta22/delta33_moment, in_last
//   result   | out_valid      | out_alpha/zeta_moment, end_of_run, overflowed
//
// Load: one beat per cycle while busy is low. After the last beat, degrees
// 0 and 1 are each emitted as a zero result; degree l >= 2 runs l MAC
// steps over one store read port, a short combine pipeline, then two
// 32-step restoring dividers running in parallel.
// Reset is synchronous (rst_n low); results are strobed for one cycle and
// cannot be stalled. busy stays high until the last result is issued.
// ----------------------------------------------------------------------------
`default_nettype none
module phase_moment_completion_core #(
  parameter int MAX_DEGREE = pmc_pkg::MAX_DEGREE
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [pmc_pkg::MOM_W-1:0]  in_beta11_moment,
  input  wire logic signed [pmc_pkg::MOM_W-1:0]  in_beta22_moment,
  input  wire logic signed [pmc_pkg::MOM_W-1:0]  in_delta33_moment,
  input  wire logic                              in_last,
  output logic                                   out_valid,
  output logic signed [pmc_pkg::MOM_W-1:0]       out_alpha_moment,
  output logic signed [pmc_pkg::MOM_W-1:0]       out_zeta_moment,
  output logic                                   out_end_of_run,
  output logic                                   out_overflowed
);

  pmc_pkg::pmc_cmd_t cmd;
  pmc_pkg::pmc_sts_t sts;

  pmc_ctrl #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_last),
    .busy    (busy),
    .cmd     (cmd),
    .sts     (sts)
  );

  pmc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_beta11_moment  (in_beta11_moment),
    .in_beta22_moment  (in_beta22_moment),
    .in_delta33_moment (in_delta33_moment),
    .out_valid         (out_valid),
    .out_alpha_moment  (out_alpha_moment),
    .out_zeta_moment   (out_zeta_moment),
    .out_end_of_run    (out_end_of_run),
    .out_overflowed    (out_overflowed)
  );

endmodule
`default_nettype wire

// ===== tb/tb_pmc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pmc_checker
// Watches accepted input beats, computes the expected alpha/zeta moments of
// each completed load, and compares every result beat field by field.
// ----------------------------------------------------------------------------
module tb_pmc_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             busy,
  input  logic signed [pmc_pkg::MOM_W-1:0] in_beta11_moment,
  input  logic signed [pmc_pkg::MOM_W-1:0] in_beta22_moment,
  input  logic signed [pmc_pkg::MOM_W-1:0] in_delta33_moment,
  input  logic                             in_last,
  input  logic                             out_valid,
  input  logic signed [pmc_pkg::MOM_W-1:0] out_alpha_moment,
  input  logic signed [pmc_pkg::MOM_W-1:0] out_zeta_moment,
  input  logic                             out_end_of_run,
  input  logic                             out_overflowed,
  output int                               fail_count,
  output int                               pending_count
);

  typedef struct {
    logic signed [pmc_pkg::MOM_W-1:0] alpha;
    logic signed [pmc_pkg::MOM_W-1:0] zeta;
    logic                             eor;
    logic                             ovf;
  } moment_beat_t;

  localparam int CAPACITY = pmc_pkg::MAX_DEGREE + 1;

  logic signed [pmc_pkg::MOM_W-1:0] b11_mem [pmc_pkg::STORE_DEPTH];
  logic signed [pmc_pkg::MOM_W-1:0] b22_mem [pmc_pkg::STORE_DEPTH];
  logic signed [pmc_pkg::MOM_W-1:0] d33_mem [pmc_pkg::STORE_DEPTH];
  int                               loaded;
  logic                             dropped;
  moment_beat_t                     expected_q[$];

  function automatic logic signed [pmc_pkg::MOM_W-1:0] div_round_sat(longint num,
                                                                      longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    if (num < 0) q = -q;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[pmc_pkg::MOM_W-1:0];
  endfunction

  task automatic complete_load();
    moment_beat_t r;
    longint l, ord, gap, w2, sb, sd, ob, od, scn, cpn, den;
    for (int d = 0; d < loaded; d++) begin
      r.alpha = '0;
      r.zeta  = '0;
      r.eor   = (d + 1 == loaded);
      r.ovf   = dropped;
      if (d >= 2) begin
        l = d;
        sb = 0; sd = 0; ob = 0; od = 0;
        for (ord = 0; ord < l; ord++) begin
          gap = l - ord;
          w2  = 2 * (l - 1) * (l - 1) - 3 * (gap - 1) * (l + ord);
          if (gap % 2 == 0) begin
            sb += w2 * longint'(b11_mem[ord]);
            sd += w2 * longint'(d33_mem[ord]);
          end else begin
            ob += w2 * longint'(b22_mem[ord]);
            od += w2 * longint'(d33_mem[ord]);
          end
        end
        scn = 2 * l * l * (l - 1) * (l - 1);
        cpn = 4 * (2 * l + 1);
        den = 2 * l * (l - 1) * (l + 1) * (l + 2);
        r.zeta  = div_round_sat(scn * longint'(d33_mem[d]) - cpn * (sd - ob), den);
        r.alpha = div_round_sat(scn * longint'(b11_mem[d]) - cpn * (sb - od), den);
      end
      expected_q.push_back(r);
    end
    loaded  = 0;
    dropped = 1'b0;
  endtask

  task automatic report(string what, logic [pmc_pkg::MOM_W-1:0] got,
                        logic [pmc_pkg::MOM_W-1:0] want);
    $display("[%0t] %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count    = 0;
    pending_count = 0;
    loaded        = 0;
    dropped       = 1'b0;
  end

  always @(posedge clk) begin
    moment_beat_t e;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          report("unexpected result beat", out_alpha_moment, '0);
        end else begin
          e = expected_q.pop_front();
          if (out_alpha_moment !== e.alpha) report("alpha", out_alpha_moment, e.alpha);
          if (out_zeta_moment !== e.zeta) report("zeta", out_zeta_moment, e.zeta);
          if (out_end_of_run !== e.eor) report("end_of_run", out_end_of_run, e.eor);
          if (out_overflowed !== e.ovf) report("overflowed", out_overflowed, e.ovf);
        end
      end
      if (start && !busy) begin
        if (loaded < CAPACITY) begin
          b11_mem[loaded] = in_beta11_moment;
          b22_mem[loaded] = in_beta22_moment;
          d33_mem[loaded] = in_delta33_moment;
          loaded++;
        end else begin
          dropped = 1'b1;
        end
        if (in_last) complete_load();
      end
    end
    pending_count = expected_q.size();
  end
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives degree loads of varied length and content into the moment
// completion core with random gaps; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 20000;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             start = 1'b0;
  logic                             busy;
  logic signed [pmc_pkg::MOM_W-1:0] in_beta11_moment = '0;
  logic signed [pmc_pkg::MOM_W-1:0] in_beta22_moment = '0;
  logic signed [pmc_pkg::MOM_W-1:0] in_delta33_moment = '0;
  logic                             in_last = 1'b0;
  logic                             out_valid;
  logic signed [pmc_pkg::MOM_W-1:0] out_alpha_moment;
  logic signed [pmc_pkg::MOM_W-1:0] out_zeta_moment;
  logic                             out_end_of_run;
  logic                             out_overflowed;
  int                               fail_count;
  int                               pending_count;
  int                               idle_cycles = 0;
  int                               beats_sent = 0;

  always #5 clk = ~clk;

  phase_moment_completion_core dut (
    .clk, .rst_n, .start, .busy,
    .in_beta11_moment, .in_beta22_moment, .in_delta33_moment, .in_last,
    .out_valid, .out_alpha_moment, .out_zeta_moment, .out_end_of_run, .out_overflowed
  );

  tb_pmc_checker checker_i (
    .clk, .rst_n, .start, .busy,
    .in_beta11_moment, .in_beta22_moment, .in_delta33_moment, .in_last,
    .out_valid, .out_alpha_moment, .out_zeta_moment, .out_end_of_run, .out_overflowed,
    .fail_count, .pending_count
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("phase_moment_completion_core: mismatch");
      $finish;
    end
  end

  function automatic logic [pmc_pkg::MOM_W-1:0] pick_moment(int kind);
    case (kind)
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return '0;
      3: return $urandom_range(0, 4095) - 2048;
      default: return $urandom();
    endcase
  endfunction

  // one beat; mode 0 random values, 1 all max, 2 all min, 3 mixed extremes
  task automatic send_beat(int mode, logic last);
    int gap;
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(5, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_last <= last;
    case (mode)
      1: begin
        in_beta11_moment <= 32'h7fffffff; in_beta22_moment <= 32'h7fffffff;
        in_delta33_moment <= 32'h7fffffff;
      end
      2: begin
        in_beta11_moment <= 32'h80000000; in_beta22_moment <= 32'h80000000;
        in_delta33_moment <= 32'h80000000;
      end
      3: begin
        in_beta11_moment <= pick_moment($urandom_range(0, 1));
        in_beta22_moment <= pick_moment($urandom_range(0, 1));
        in_delta33_moment <= pick_moment($urandom_range(0, 1));
      end
      default: begin
        in_beta11_moment <= pick_moment($urandom_range(0, 5));
        in_beta22_moment <= pick_moment($urandom_range(0, 5));
        in_delta33_moment <= pick_moment($urandom_range(0, 5));
      end
    endcase
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_load(int len, int mode);
    for (int i = 0; i < len; i++) send_beat(mode, i == len - 1);
  endtask

  // stop sending and hold off until every expected result has come
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    @(posedge clk);
  endtask

  initial begin
    int len;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: shortest loads, extremes, full capacity, overflow
    send_load(1, 1);
    send_load(2, 2);
    send_load(3, 1);
    send_load(4, 2);
    send_load(5, 3);
    send_load(64, 1);
    drain();
    send_load(66, 3);
    send_load(64, 2);
    // random loads, mostly short
    while (beats_sent < 270) begin
      len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 70);
      send_load(len, ($urandom_range(0, 9) < 8) ? 0 : $urandom_range(1, 3));
      if ($urandom_range(0, 9) == 0) drain();
    end
    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("phase_moment_completion_core: match");
    end else begin
      $display("phase_moment_completion_core: mismatch");
    end
    $finish;
  end
endmodule
